FILE: sv/ipv4pf_pkg.sv
package ipv4pf_pkg;

	// Default depth of the rule table.
	localparam int RULE_ENTRIES_DEF = 16;

	// Frame layout.
	localparam int ETH_LEN     = 14;
	localparam int IP_MIN_LEN  = 20;
	localparam int TCP_HDR_LEN = 20;
	localparam int UDP_HDR_LEN = 8;
	localparam int SRC_IP_OFS  = 12;
	localparam int DST_IP_OFS  = 16;
	localparam int PROTO_OFS   = 9;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// Input commands.
	localparam logic CMD_ADD_RULE = 1'b0;
	localparam logic CMD_BYTE     = 1'b1;

	// Parse status codes.
	localparam logic [2:0] PS_TCP         = 3'd0;
	localparam logic [2:0] PS_UDP         = 3'd1;
	localparam logic [2:0] PS_SHORT_IP    = 3'd2;
	localparam logic [2:0] PS_OTHER_PROTO = 3'd3;
	localparam logic [2:0] PS_SHORT_TP    = 3'd4;

	// One stored rule: addresses, then source port over destination port.
	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] ports;
	} rule_t;

endpackage

FILE: sv/ipv4pf_ram.sv
module ipv4pf_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sv/ipv4_port_tuple_packet_filter_unit.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid, in_stall   | cmd, rule_src_ip, rule_dst_ip, rule_src_port,
//          |                      | rule_dst_port, frame_byte, frame_last
// out      | out_valid, out_stall | is_rule_ack, rule_stored, drop, parse_status
//
// A frame byte that is not the last one is taken in IDLE and a rule add goes to FINISH.
// A last frame byte goes through VERDICT, then READ and CMP for each stored rule
// searched, then FINISH, one rule at a time over the one read port and comparator.
// Reset clears the rule count and all per-frame state but not the rule memory.
// A stalled result waits in the output register while beats are still taken; a
// second result waits in FINISH with in_stall high until the register frees up.
module ipv4_port_tuple_packet_filter_unit
	import ipv4pf_pkg::*;
#(
	parameter int RULE_ENTRIES = RULE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] rule_src_ip,
	input  logic [31:0] rule_dst_ip,
	input  logic [15:0] rule_src_port,
	input  logic [15:0] rule_dst_port,
	input  logic [7:0]  frame_byte,
	input  logic        frame_last,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_rule_ack,
	output logic        rule_stored,
	output logic        drop,
	output logic [2:0]  parse_status
);

	localparam int AW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
	localparam int CW = $clog2(RULE_ENTRIES + 1);

	// The sequencer: IDLE takes beats, VERDICT classifies a finished frame,
	// READ and CMP walk the rule memory one entry per READ and CMP pair, and
	// FINISH hands the result to the output register.
	typedef enum logic [2:0] {
		S_IDLE,
		S_VERDICT,
		S_READ,
		S_CMP,
		S_FINISH
	} state_t;

	state_t      state_q;
	logic [CW-1:0] rule_count_q;
	logic [AW-1:0] idx_q;

	logic [15:0] byte_index_q;
	logic [3:0]  ip_header_words_q;
	logic [7:0]  ip_protocol_q;
	logic [31:0] frame_src_ip_q;
	logic [31:0] frame_dst_ip_q;
	logic [31:0] frame_ports_q;

	// Result waiting for the output register.
	logic        res_ack_q;
	logic        res_stored_q;
	logic        res_drop_q;
	logic [2:0]  res_status_q;

	logic        out_valid_q;
	logic        is_rule_ack_q;
	logic        rule_stored_q;
	logic        drop_q;
	logic [2:0]  parse_status_q;

	logic        accept;
	logic        out_free;

	// Rule memory port signals.
	logic        ram_wr_en;
	rule_t       ram_wr_data;
	rule_t       ram_rd_data;
	logic        ram_rd_en;

	// Next values of the per-frame capture registers for one frame byte.
	logic [15:0] byte_index_nxt;
	logic [3:0]  ihl_nxt;
	logic [7:0]  proto_nxt;
	logic [31:0] src_ip_nxt;
	logic [31:0] dst_ip_nxt;
	logic [31:0] ports_nxt;
	logic [6:0]  tp_start;
	logic [16:0] src_diff;
	logic [16:0] dst_diff;
	logic [16:0] tp_diff;

	// Frame verdict terms.
	logic [16:0] total_len;
	logic [16:0] hdr_end;
	logic [16:0] tp_end;
	logic        is_tcp;
	logic        is_udp;
	logic [2:0]  verdict_status;
	logic        verdict_search;
	logic        rule_hit;
	logic        last_entry;

	// Places one byte into a 32-bit word; lane 0 is the first wire byte.
	function automatic logic [31:0] put_byte(logic [31:0] word, logic [7:0] b,
			logic [1:0] lane);
		logic [31:0] r;
		r = word;
		case (lane)
			2'd0: r[31:24] = r[31:24] | b;
			2'd1: r[23:16] = r[23:16] | b;
			2'd2: r[15:8]  = r[15:8]  | b;
			default: r[7:0] = r[7:0] | b;
		endcase
		return r;
	endfunction

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign is_rule_ack  = is_rule_ack_q;
	assign rule_stored  = rule_stored_q;
	assign drop         = drop_q;
	assign parse_status = parse_status_q;

	// Frame byte capture. The header length may change at this very byte, so
	// the transport start is taken from its next value.
	always_comb begin
		ihl_nxt = ip_header_words_q;
		if (byte_index_q == 16'(ETH_LEN)) begin
			ihl_nxt = frame_byte[3:0];
		end
		proto_nxt = ip_protocol_q;
		if (byte_index_q == 16'(ETH_LEN + PROTO_OFS)) begin
			proto_nxt = frame_byte;
		end

		src_diff = {1'b0, byte_index_q} - 17'(ETH_LEN + SRC_IP_OFS);
		dst_diff = {1'b0, byte_index_q} - 17'(ETH_LEN + DST_IP_OFS);
		tp_start = 7'(ETH_LEN) + {1'b0, ihl_nxt, 2'b00};
		tp_diff  = {1'b0, byte_index_q} - {10'd0, tp_start};

		src_ip_nxt = frame_src_ip_q;
		if (src_diff < 17'd4) begin
			src_ip_nxt = put_byte(frame_src_ip_q, frame_byte, src_diff[1:0]);
		end
		dst_ip_nxt = frame_dst_ip_q;
		if (dst_diff < 17'd4) begin
			dst_ip_nxt = put_byte(frame_dst_ip_q, frame_byte, dst_diff[1:0]);
		end
		ports_nxt = frame_ports_q;
		if (tp_diff < 17'd4) begin
			ports_nxt = put_byte(frame_ports_q, frame_byte, tp_diff[1:0]);
		end

		byte_index_nxt = byte_index_q;
		if (byte_index_q != 16'hFFFF) begin
			byte_index_nxt = byte_index_q + 16'd1;
		end
	end

	// Frame classification. A saturated byte count stands for a length that
	// passes every check.
	always_comb begin
		total_len = {1'b0, byte_index_q} + ((byte_index_q == 16'hFFFF) ? 17'd1 : 17'd0);
		hdr_end   = 17'(ETH_LEN) + {11'd0, ip_header_words_q, 2'b00};
		is_tcp    = (ip_protocol_q == PROTO_TCP);
		is_udp    = (ip_protocol_q == PROTO_UDP);
		tp_end    = hdr_end + (is_tcp ? 17'(TCP_HDR_LEN) : 17'(UDP_HDR_LEN));
		verdict_search = 1'b0;
		if (total_len < 17'(ETH_LEN + IP_MIN_LEN) || total_len < hdr_end) begin
			verdict_status = PS_SHORT_IP;
		end else if (!is_tcp && !is_udp) begin
			verdict_status = PS_OTHER_PROTO;
		end else if (total_len < tp_end) begin
			verdict_status = PS_SHORT_TP;
		end else begin
			verdict_status = is_tcp ? PS_TCP : PS_UDP;
			verdict_search = 1'b1;
		end
	end

	assign rule_hit   = (ram_rd_data.src_ip == frame_src_ip_q) &&
	                    (ram_rd_data.dst_ip == frame_dst_ip_q) &&
	                    (ram_rd_data.ports  == frame_ports_q);
	assign last_entry = ((CW'(idx_q) + CW'(1)) == rule_count_q);

	// New rules are appended at the current count.
	assign ram_wr_en   = accept && (cmd == CMD_ADD_RULE) &&
	                     (rule_count_q < CW'(RULE_ENTRIES));
	assign ram_wr_data = '{src_ip: rule_src_ip, dst_ip: rule_dst_ip,
	                       ports: {rule_src_port, rule_dst_port}};
	assign ram_rd_en   = (state_q == S_READ);

	ipv4pf_ram #(
		.WIDTH($bits(rule_t)),
		.DEPTH(RULE_ENTRIES)
	) u_rule_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (rule_count_q[AW-1:0]),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			rule_count_q      <= '0;
			idx_q             <= '0;
			byte_index_q      <= '0;
			ip_header_words_q <= '0;
			ip_protocol_q     <= '0;
			frame_src_ip_q    <= '0;
			frame_dst_ip_q    <= '0;
			frame_ports_q     <= '0;
			res_ack_q         <= 1'b0;
			res_stored_q      <= 1'b0;
			res_drop_q        <= 1'b0;
			res_status_q      <= PS_TCP;
			out_valid_q       <= 1'b0;
			is_rule_ack_q     <= 1'b0;
			rule_stored_q     <= 1'b0;
			drop_q            <= 1'b0;
			parse_status_q    <= PS_TCP;
		end else begin
			// In FINISH the output register is refilled below instead.
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_ADD_RULE) begin
							res_ack_q    <= 1'b1;
							res_stored_q <= ram_wr_en;
							res_drop_q   <= 1'b0;
							res_status_q <= PS_TCP;
							if (ram_wr_en) begin
								rule_count_q <= rule_count_q + CW'(1);
							end
							state_q <= S_FINISH;
						end else begin
							byte_index_q      <= byte_index_nxt;
							ip_header_words_q <= ihl_nxt;
							ip_protocol_q     <= proto_nxt;
							frame_src_ip_q    <= src_ip_nxt;
							frame_dst_ip_q    <= dst_ip_nxt;
							frame_ports_q     <= ports_nxt;
							if (frame_last) begin
								state_q <= S_VERDICT;
							end
						end
					end
				end

				S_VERDICT: begin
					res_ack_q    <= 1'b0;
					res_stored_q <= 1'b0;
					res_drop_q   <= 1'b0;
					res_status_q <= verdict_status;
					idx_q        <= '0;
					if (verdict_search && rule_count_q != '0) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_FINISH;
					end
				end

				S_READ: begin
					state_q <= S_CMP;
				end

				S_CMP: begin
					if (rule_hit) begin
						res_drop_q <= 1'b1;
						state_q    <= S_FINISH;
					end else if (last_entry) begin
						state_q <= S_FINISH;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_READ;
					end
				end

				S_FINISH: begin
					// A frame verdict ends the frame, so its capture state is
					// cleared for the next one here.
					if (!res_ack_q) begin
						byte_index_q      <= '0;
						ip_header_words_q <= '0;
						ip_protocol_q     <= '0;
						frame_src_ip_q    <= '0;
						frame_dst_ip_q    <= '0;
						frame_ports_q     <= '0;
					end
					if (out_free) begin
						out_valid_q    <= 1'b1;
						is_rule_ack_q  <= res_ack_q;
						rule_stored_q  <= res_stored_q;
						drop_q         <= res_drop_q;
						parse_status_q <= res_status_q;
						state_q        <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: verif/ipv4_port_tuple_packet_filter_unit_test.sv
`timescale 1ns / 100ps

module ipv4_port_tuple_packet_filter_unit_test
	import ipv4pf_pkg::*;
();

	localparam int TABLE_DEPTH = RULE_ENTRIES_DEF;
	localparam int MAX_GAP = 13;
	// A last byte may search the whole table.
	localparam int SEARCH_CYCLES = 3 + 2 * TABLE_DEPTH;
	localparam int STALL_HOLD_CYCLES = 400;
	localparam int RANDOM_BEATS = 60;
	localparam int RANDOM_ANSWERS = 3;
	// The limit allows several times the slowest correct run.
	localparam longint RUN_LIMIT_NS = 64'd2_000_000;

	// One input beat: a rule add or a frame byte, with every payload field.
	typedef struct {
		logic        cmd;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  fbyte;
		logic        flast;
	} filter_beat_t;

	// One answer from the block: a rule acknowledge or a frame verdict.
	typedef struct packed {
		logic       is_ack;
		logic       stored;
		logic       drop;
		logic [2:0] status;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [31:0] rule_src_ip;
	logic [31:0] rule_dst_ip;
	logic [15:0] rule_src_port;
	logic [15:0] rule_dst_port;
	logic [7:0]  frame_byte;
	logic        frame_last;
	logic        out_valid;
	logic        out_stall;
	logic        is_rule_ack;
	logic        rule_stored;
	logic        drop;
	logic [2:0]  parse_status;

	ipv4_port_tuple_packet_filter_unit #(
		.RULE_ENTRIES(TABLE_DEPTH)
	) u_dut (.*);

	// Our own copy of the filter state, advanced once per accepted beat.
	rule_t       known_rules [TABLE_DEPTH];
	int          known_rule_count = 0;
	int          byte_pos = 0;
	logic [3:0]  hdr_words = '0;
	logic [7:0]  proto_seen = '0;
	logic [31:0] seen_src_ip = '0;
	logic [31:0] seen_dst_ip = '0;
	logic [31:0] seen_ports = '0;

	// Answers still owed by the block, oldest first.
	verdict_t    expected_verdicts [$];

	int          error_count = 0;
	int          beats_sent = 0;
	int          answers_owed_total = 0;

	// Idle control shared by the sender and the receiver. A nonzero hold
	// request sets the length of one unbroken receiver stall.
	bit          src_gaps_on = 1'b1;
	bit          sink_gaps_on = 1'b1;
	int          hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run must never hang; a stuck handshake ends here.
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL ipv4_port_tuple_packet_filter_unit");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Advance the filter state by one accepted beat and queue any answer it owes.
	task automatic predict_beat(input filter_beat_t b);
		int       tstart;
		int       total;
		int       hlen;
		int       rest;
		int       need;
		int       k;
		verdict_t v;
		v = '0;
		if (b.cmd == CMD_ADD_RULE) begin
			// A full table rejects the rule but still answers.
			v.is_ack = 1'b1;
			if (known_rule_count < TABLE_DEPTH) begin
				known_rules[known_rule_count] = '{b.src_ip, b.dst_ip,
					{b.src_port, b.dst_port}};
				known_rule_count++;
				v.stored = 1'b1;
			end
			expected_verdicts.insert(expected_verdicts.size(), v);
			answers_owed_total++;
		end else begin
			// Each byte position is seen once per frame, so the captured
			// fields can be filled byte by byte from zero.
			if (byte_pos == ETH_LEN)
				hdr_words = b.fbyte[3:0];
			if (byte_pos == ETH_LEN + PROTO_OFS)
				proto_seen = b.fbyte;
			if (byte_pos >= ETH_LEN + SRC_IP_OFS && byte_pos < ETH_LEN + SRC_IP_OFS + 4)
				seen_src_ip[8 * (ETH_LEN + SRC_IP_OFS + 3 - byte_pos) +: 8] = b.fbyte;
			if (byte_pos >= ETH_LEN + DST_IP_OFS && byte_pos < ETH_LEN + DST_IP_OFS + 4)
				seen_dst_ip[8 * (ETH_LEN + DST_IP_OFS + 3 - byte_pos) +: 8] = b.fbyte;
			// The transport header starts right after the IP header as its
			// length field says, even where a short length makes them overlap.
			tstart = ETH_LEN + 4 * int'(hdr_words);
			if (byte_pos >= tstart && byte_pos < tstart + 4)
				seen_ports[8 * (tstart + 3 - byte_pos) +: 8] = b.fbyte;
			if (byte_pos < 65535)
				byte_pos++;

			if (b.flast) begin
				// A saturated counter reads as one more, so the length checks pass.
				total = byte_pos + ((byte_pos == 65535) ? 1 : 0);
				hlen = 4 * int'(hdr_words);
				if (total < ETH_LEN + IP_MIN_LEN || total < ETH_LEN + hlen) begin
					v.status = PS_SHORT_IP;
				end else if (proto_seen != PROTO_TCP && proto_seen != PROTO_UDP) begin
					v.status = PS_OTHER_PROTO;
				end else begin
					rest = total - ETH_LEN - hlen;
					need = (proto_seen == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
					if (rest < need) begin
						v.status = PS_SHORT_TP;
					end else begin
						v.status = (proto_seen == PROTO_TCP) ? PS_TCP : PS_UDP;
						for (k = 0; k < known_rule_count; k++) begin
							if (known_rules[k].src_ip == seen_src_ip &&
								known_rules[k].dst_ip == seen_dst_ip &&
								known_rules[k].ports == seen_ports)
								v.drop = 1'b1;
						end
					end
				end
				expected_verdicts.insert(expected_verdicts.size(), v);
				answers_owed_total++;
				byte_pos = 0;
				hdr_words = '0;
				proto_seen = '0;
				seen_src_ip = '0;
				seen_dst_ip = '0;
				seen_ports = '0;
			end
		end
	endtask

	// Offer one beat after a random gap and hold it until the block takes it.
	// Valid is left high on return, so a following beat with no gap goes out
	// back to back; any pause must go through pause_sender.
	task automatic send_beat(input filter_beat_t b);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= b.cmd;
		rule_src_ip   <= b.src_ip;
		rule_dst_ip   <= b.dst_ip;
		rule_src_port <= b.src_port;
		rule_dst_port <= b.dst_port;
		frame_byte    <= b.fbyte;
		frame_last    <= b.flast;
		do
			@(posedge clk);
		while (in_stall);
		predict_beat(b);
		beats_sent++;
	endtask

	task automatic pause_sender();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_all_answered();
		pause_sender();
		while (expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Frame fields of a rule add are filled with noise, and the other way round.
	function automatic filter_beat_t rule_beat(input logic [31:0] sip, input logic [31:0] dip,
		input logic [15:0] sp, input logic [15:0] dp);
		filter_beat_t b;
		b.cmd = CMD_ADD_RULE;
		b.src_ip = sip;
		b.dst_ip = dip;
		b.src_port = sp;
		b.dst_port = dp;
		b.fbyte = 8'($urandom_range(0, 255));
		b.flast = 1'($urandom_range(0, 1));
		return b;
	endfunction

	function automatic filter_beat_t frame_beat(input logic [7:0] val, input logic last);
		filter_beat_t b;
		b.cmd = CMD_BYTE;
		b.src_ip = $urandom;
		b.dst_ip = $urandom;
		b.src_port = 16'($urandom_range(0, 65535));
		b.dst_port = 16'($urandom_range(0, 65535));
		b.fbyte = val;
		b.flast = last;
		return b;
	endfunction

	task automatic send_random_rule();
		send_beat(rule_beat($urandom, $urandom, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535))));
	endtask

	// Most tuples come from stored rules, some of them with one bit flipped so
	// that they just miss, and the rest are random.
	task automatic pick_tuple(output logic [31:0] sip, output logic [31:0] dip,
		output logic [15:0] sp, output logic [15:0] dp);
		int    pick;
		int    bitpos;
		rule_t r;
		pick = $urandom_range(0, 99);
		sip = $urandom;
		dip = $urandom;
		sp = 16'($urandom_range(0, 65535));
		dp = 16'($urandom_range(0, 65535));
		if (pick < 70 && known_rule_count > 0) begin
			r = known_rules[$urandom_range(0, known_rule_count - 1)];
			sip = r.src_ip;
			dip = r.dst_ip;
			sp = r.ports[31:16];
			dp = r.ports[15:0];
			if (pick >= 45) begin
				bitpos = $urandom_range(0, 31);
				case ($urandom_range(0, 3))
					0: sip[bitpos] = ~sip[bitpos];
					1: dip[bitpos] = ~dip[bitpos];
					2: sp[bitpos % 16] = ~sp[bitpos % 16];
					default: dp[bitpos % 16] = ~dp[bitpos % 16];
				endcase
			end
		end
	endtask

	// Build a frame of len bytes around random filler and send it byte by byte.
	// A rule for the frame's own tuple goes in just before byte mid_add_at
	// (none when negative); noise_pct is the chance of a random rule add before
	// any byte.
	task automatic send_frame(input logic [7:0] proto, input logic [3:0] words,
		input logic [31:0] sip, input logic [31:0] dip, input logic [15:0] sp,
		input logic [15:0] dp, input int len, input int mid_add_at, input int noise_pct);
		logic [7:0] fbytes [];
		int         tstart;
		int         k;
		fbytes = new[len];
		foreach (fbytes[k])
			fbytes[k] = 8'($urandom_range(0, 255));
		// Ports go in first so that the IP header wins where the two overlap.
		tstart = ETH_LEN + 4 * int'(words);
		for (k = 0; k < 4; k++) begin
			if (tstart + k < len)
				fbytes[tstart + k] = (k < 2) ? sp[8 * (1 - k) +: 8] : dp[8 * (3 - k) +: 8];
		end
		if (ETH_LEN < len)
			fbytes[ETH_LEN] = {fbytes[ETH_LEN][7:4], words};
		if (ETH_LEN + PROTO_OFS < len)
			fbytes[ETH_LEN + PROTO_OFS] = proto;
		for (k = 0; k < 4; k++) begin
			if (ETH_LEN + SRC_IP_OFS + k < len)
				fbytes[ETH_LEN + SRC_IP_OFS + k] = sip[8 * (3 - k) +: 8];
			if (ETH_LEN + DST_IP_OFS + k < len)
				fbytes[ETH_LEN + DST_IP_OFS + k] = dip[8 * (3 - k) +: 8];
		end
		for (k = 0; k < len; k++) begin
			if (k == mid_add_at)
				send_beat(rule_beat(sip, dip, sp, dp));
			else if ($urandom_range(0, 99) < noise_pct)
				send_random_rule();
			send_beat(frame_beat(fbytes[k], k == len - 1));
		end
	endtask

	// Rules at the extremes of every field, plus one stored twice.
	task automatic test_rule_adds();
		send_beat(rule_beat('1, '1, '1, '1));
		send_beat(rule_beat('0, '0, '0, '0));
		send_beat(rule_beat(32'hC0A8_0001, 32'h0A00_0002, 16'd80, 16'd443));
		send_beat(rule_beat(32'hC0A8_0001, 32'h0A00_0002, 16'd80, 16'd443));
		send_beat(rule_beat(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555));
	endtask

	// One frame per parse outcome and per odd header shape.
	task automatic test_frame_cases();
		// Matching TCP and UDP frames; the UDP one is exactly long enough.
		send_frame(PROTO_TCP, 4'd5, 32'hC0A8_0001, 32'h0A00_0002, 16'd80, 16'd443, 54, -1, 0);
		send_frame(PROTO_UDP, 4'd5, '1, '1, '1, '1, 42, -1, 0);
		// One byte short of a UDP header.
		send_frame(PROTO_UDP, 4'd5, '0, '0, '0, '0, 41, -1, 0);
		// Same addresses, different destination port: kept.
		send_frame(PROTO_TCP, 4'd5, 32'hC0A8_0001, 32'h0A00_0002, 16'd80, 16'd444, 60, -1, 0);
		// Frames too short for the Ethernet or IP header.
		send_frame(PROTO_TCP, 4'd5, '0, '0, '0, '0, 1, -1, 0);
		send_frame(PROTO_TCP, 4'd5, '0, '0, '0, '0, 33, -1, 0);
		// Header lengths under five words put the ports inside the IP header.
		send_frame(PROTO_TCP, 4'd0, '0, '0, '0, '0, 40, -1, 0);
		send_frame(PROTO_UDP, 4'd2, '1, '1, '1, '1, 34, -1, 0);
		// Longest IP header: too short overall, short transport, then a match.
		send_frame(PROTO_TCP, 4'd15, '0, '0, '0, '0, 70, -1, 0);
		send_frame(PROTO_TCP, 4'd15, '0, '0, '0, '0, 93, -1, 0);
		send_frame(PROTO_TCP, 4'd15, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555,
			94, -1, 0);
		// Neither TCP nor UDP, even with a tuple that is in the table.
		send_frame(8'd1, 4'd5, 32'hC0A8_0001, 32'h0A00_0002, 16'd80, 16'd443, 60, -1, 0);
		send_frame(8'hFF, 4'd5, '1, '1, '1, '1, 60, -1, 0);
		// A rule added halfway through a frame already counts for that frame.
		send_frame(PROTO_TCP, 4'd5, 32'h0102_0304, 32'h0506_0708, 16'h090A, 16'h0B0C,
			54, 20, 0);
	endtask

	// Mostly well-formed frames with random content, with short, odd and
	// foreign frames and rule adds mixed in. Idling is switched on and off
	// in stretches on both sides.
	task automatic test_random_traffic();
		int          start_beats;
		int          start_answers;
		int          kind;
		int          words;
		int          need;
		int          len;
		logic [7:0]  proto;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sp;
		logic [15:0] dp;
		start_beats = beats_sent;
		start_answers = answers_owed_total;
		while (beats_sent - start_beats < RANDOM_BEATS ||
			answers_owed_total - start_answers < RANDOM_ANSWERS) begin
			if ($urandom_range(0, 3) == 0) begin
				src_gaps_on = 1'($urandom_range(0, 1));
				sink_gaps_on = 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 9) < 3) begin
				pick_tuple(sip, dip, sp, dp);
				send_beat(rule_beat(sip, dip, sp, dp));
			end else begin
				kind = $urandom_range(0, 9);
				proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
				words = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
				need = (proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
				len = ETH_LEN + 4 * words + need + $urandom_range(0, 6);
				pick_tuple(sip, dip, sp, dp);
				case (kind)
					7: proto = 8'($urandom_range(0, 255));
					8: len = $urandom_range(1, ETH_LEN + 4 * words + need - 1);
					9: begin
						words = $urandom_range(0, 4);
						len = $urandom_range(ETH_LEN, 60);
					end
					default: ;
				endcase
				send_frame(proto, words[3:0], sip, dip, sp, dp, len, -1, 3);
			end
		end
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b1;
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering beats back to back, so both result slots fill and the block
	// stalls its input. Afterwards the sender waits for every answer.
	task automatic test_back_pressure();
		int          k;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sp;
		logic [15:0] dp;
		src_gaps_on = 1'b0;
		sink_gaps_on = 1'b0;
		hold_request = STALL_HOLD_CYCLES;
		for (k = 0; k < 4; k++) begin
			send_random_rule();
			pick_tuple(sip, dip, sp, dp);
			send_frame(PROTO_UDP, 4'd5, sip, dip, sp, dp, 42, -1, 0);
		end
		wait_all_answered();
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b1;
	endtask

	// Fill the table, push past its end, then match its very last entry.
	task automatic test_table_full();
		rule_t last_rule;
		while (known_rule_count < TABLE_DEPTH)
			send_random_rule();
		repeat (3) send_random_rule();
		last_rule = known_rules[TABLE_DEPTH - 1];
		send_frame(PROTO_TCP, 4'd5, last_rule.src_ip, last_rule.dst_ip,
			last_rule.ports[31:16], last_rule.ports[15:0], 54, -1, 0);
	endtask

	// Receiver: for every answer it draws a random stall, or takes a pending
	// hold request, then stays ready until the beat moves.
	initial begin
		int stall_len;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				stall_len = hold_request;
				hold_request = 0;
			end else begin
				stall_len = sink_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (stall_len != 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// Every answer that moves is checked against the oldest one owed.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("answer with none owed, is_rule_ack", int'(is_rule_ack), 0);
			end else begin
				want = expected_verdicts.pop_front();
				if (is_rule_ack !== want.is_ack)
					report_mismatch("is_rule_ack", int'(is_rule_ack), int'(want.is_ack));
				if (rule_stored !== want.stored)
					report_mismatch("rule_stored", int'(rule_stored), int'(want.stored));
				if (drop !== want.drop)
					report_mismatch("drop", int'(drop), int'(want.drop));
				if (parse_status !== want.status)
					report_mismatch("parse_status", int'(parse_status), int'(want.status));
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = CMD_BYTE;
		rule_src_ip   = '0;
		rule_dst_ip   = '0;
		rule_src_port = '0;
		rule_dst_port = '0;
		frame_byte    = '0;
		frame_last    = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_rule_adds();
		test_frame_cases();
		test_random_traffic();
		test_back_pressure();
		test_table_full();

		// Let the last search finish and make sure nothing extra comes out.
		wait_all_answered();
		repeat (SEARCH_CYCLES + 10) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS ipv4_port_tuple_packet_filter_unit");
		end else begin
			$display("FAIL ipv4_port_tuple_packet_filter_unit");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/ipv4pf_pkg.sv
sv/ipv4pf_ram.sv
sv/ipv4_port_tuple_packet_filter_unit.sv
verif/ipv4_port_tuple_packet_filter_unit_test.sv
